FILE: sv/lprbr_pkg.sv
// Package for the length-prefixed record BOM rewriter.
// Holds the parse phase type, the result record type and the fixed byte constants.
// Depends on nothing.
package lprbr_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LEN_LO  = 2'd1,
        PH_LEN_HI  = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    localparam logic [7:0] BOM_FIRST  = 8'hFF;
    localparam logic [7:0] BOM_SECOND = 8'hFE;
    localparam logic [2:0] COUNT_LO_POS = 3'd6;
    localparam logic [2:0] COUNT_HI_POS = 3'd7;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [19:0] offset;
        logic [14:0] index;
        logic        overflow;
        logic        last;
    } t_result;

endpackage

FILE: sv/length_prefixed_record_bom_rewriter.sv
// A result appears in the cycle after its byte is accepted, later if older results wait.
// Throughput: one byte per cycle while each byte gives at most one result and output is not
// stalled; a length high byte's three results drain from a four-entry queue and stall input.
// Reset (synchronous, active low) empties the queue and returns the parser to the header.
// Top level of the rewriter; depends on lprbr_pkg.
module length_prefixed_record_bom_rewriter #(
    parameter int OFFSET_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic [19:0] o_out_offset,
    output logic [14:0] o_string_index,
    output logic        o_overflow,
    output logic        o_last_of_run
);

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    lprbr_pkg::t_phase      r_phase, n_phase;
    logic [2:0]             r_header_pos, n_header_pos;
    logic [7:0]             r_count_lo, n_count_lo;
    logic [15:0]            r_total, n_total;
    logic [14:0]            r_done, n_done;
    logic [7:0]             r_len_lo, n_len_lo;
    logic [15:0]            r_left, n_left;
    logic [OFFSET_BITS-1:0] r_wo, n_wo;

    lprbr_pkg::t_result     r_q [4];
    logic [1:0]             r_rd;
    logic [2:0]             r_count;

    lprbr_pkg::t_result     res [3];
    logic [1:0]             push_n;
    logic                   in_take, out_take;
    logic [1:0]             wr;
    logic [2:0]             n_count;

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        sat_inc = (v == OFFSET_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [19:0] low_offset(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+19:0] ext;
        ext = (OFFSET_BITS+20)'(v);
        low_offset = ext[19:0];
    endfunction

    function automatic lprbr_pkg::t_result make_res(input logic kind, input logic [7:0] data,
        input logic [OFFSET_BITS-1:0] off, input logic [14:0] idx, input logic last);
        lprbr_pkg::t_result r;
        r.kind     = kind;
        r.data     = data;
        r.offset   = low_offset(off);
        r.index    = idx;
        r.overflow = (off == OFFSET_MAX);
        r.last     = last;
        make_res   = r;
    endfunction

    assign out_take   = o_out_valid && !i_out_stall;
    assign o_in_stall = (r_count > 3'd2) || ((r_count == 3'd2) && i_out_stall);
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        lprbr_pkg::t_phase      c_phase;
        logic [2:0]             c_hpos;
        logic [7:0]             c_clo;
        logic [15:0]            c_total;
        logic [14:0]            c_done;
        logic [7:0]             c_llo;
        logic [15:0]            c_left;
        logic [OFFSET_BITS-1:0] c_wo;
        logic [OFFSET_BITS-1:0] wo1;
        logic [15:0]            len;
        if (i_first_byte) begin
            c_phase = lprbr_pkg::PH_HEADER;
            c_hpos  = '0;
            c_clo   = '0;
            c_total = '0;
            c_done  = '0;
            c_llo   = '0;
            c_left  = '0;
            c_wo    = '0;
        end else begin
            c_phase = r_phase;
            c_hpos  = r_header_pos;
            c_clo   = r_count_lo;
            c_total = r_total;
            c_done  = r_done;
            c_llo   = r_len_lo;
            c_left  = r_left;
            c_wo    = r_wo;
        end
        wo1          = sat_inc(c_wo);
        len          = {i_data_byte, c_llo};
        n_phase      = c_phase;
        n_header_pos = c_hpos;
        n_count_lo   = c_clo;
        n_total      = c_total;
        n_done       = c_done;
        n_len_lo     = c_llo;
        n_left       = c_left;
        n_wo         = c_wo;
        push_n       = 2'd0;
        res[0]       = make_res(lprbr_pkg::KIND_DATA, i_data_byte, c_wo, c_done, 1'b1);
        res[1]       = make_res(lprbr_pkg::KIND_DATA, lprbr_pkg::BOM_FIRST, c_wo, c_done, 1'b0);
        res[2]       = make_res(lprbr_pkg::KIND_DATA, lprbr_pkg::BOM_SECOND, wo1, c_done, 1'b1);
        case (c_phase)
            lprbr_pkg::PH_HEADER: begin
                if (c_hpos == lprbr_pkg::COUNT_LO_POS) begin
                    n_count_lo = i_data_byte;
                end else if (c_hpos == lprbr_pkg::COUNT_HI_POS) begin
                    n_total = i_data_byte[7] ? 16'd0 : {i_data_byte, c_clo};
                end
                if (c_hpos == lprbr_pkg::COUNT_HI_POS) begin
                    n_header_pos = '0;
                    n_phase      = lprbr_pkg::PH_LEN_LO;
                end else begin
                    n_header_pos = c_hpos + 3'd1;
                end
            end
            lprbr_pkg::PH_LEN_LO: begin
                if (16'(c_done) < c_total) begin
                    n_len_lo = i_data_byte;
                    n_phase  = lprbr_pkg::PH_LEN_HI;
                end
            end
            lprbr_pkg::PH_LEN_HI: begin
                push_n = 2'd3;
                res[0] = make_res(lprbr_pkg::KIND_START, 8'd0, c_wo, c_done, 1'b0);
                n_wo   = sat_inc(wo1);
                if (len == 16'd0) begin
                    n_done  = c_done + 15'd1;
                    n_phase = lprbr_pkg::PH_LEN_LO;
                end else begin
                    n_left  = len;
                    n_phase = lprbr_pkg::PH_PAYLOAD;
                end
            end
            default: begin
                push_n = 2'd1;
                n_wo   = wo1;
                n_left = (c_left != 16'd0) ? c_left - 16'd1 : c_left;
                if (n_left == 16'd0) begin
                    n_done  = c_done + 15'd1;
                    n_phase = lprbr_pkg::PH_LEN_LO;
                end
            end
        endcase
    end

    assign wr      = r_rd + r_count[1:0];
    assign n_count = r_count - {2'b0, out_take} + (in_take ? {1'b0, push_n} : 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lprbr_pkg::PH_HEADER;
            r_header_pos <= '0;
            r_count_lo   <= '0;
            r_total      <= '0;
            r_done       <= '0;
            r_len_lo     <= '0;
            r_left       <= '0;
            r_wo         <= '0;
            r_rd         <= '0;
            r_count      <= '0;
        end else begin
            if (in_take) begin
                r_phase      <= n_phase;
                r_header_pos <= n_header_pos;
                r_count_lo   <= n_count_lo;
                r_total      <= n_total;
                r_done       <= n_done;
                r_len_lo     <= n_len_lo;
                r_left       <= n_left;
                r_wo         <= n_wo;
            end
            if (out_take) begin
                r_rd <= r_rd + 2'd1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            if (push_n != 2'd0) begin
                r_q[wr] <= res[0];
            end
            if (push_n == 2'd3) begin
                r_q[wr + 2'd1] <= res[1];
                r_q[wr + 2'd2] <= res[2];
            end
        end
    end

    assign o_out_valid    = (r_count != 3'd0);
    assign o_out_kind     = r_q[r_rd].kind;
    assign o_out_byte     = r_q[r_rd].data;
    assign o_out_offset   = r_q[r_rd].offset;
    assign o_string_index = r_q[r_rd].index;
    assign o_overflow     = r_q[r_rd].overflow;
    assign o_last_of_run  = r_q[r_rd].last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("Result queue holds more than four entries.");

    a_run_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_of_run) |-> (r_count >= 3'd2))
        else $error("A result that is not the last of its run has no follower queued.");

    a_offset_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && !i_first_byte) |=> (r_wo >= $past(r_wo)))
        else $error("Write offset moved backward without a new file.");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= 3'd3) |-> o_in_stall)
        else $error("Input accepted without room for three results.");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for length_prefixed_record_bom_rewriter: string-table files
// are streamed in byte by byte and every rewritten record is compared with a predictor.
// Depends on lprbr_pkg and the rewriter RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int OFFSET_W = 16;
    localparam logic [31:0] OFFSET_TOP = (32'd1 << OFFSET_W) - 32'd1;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } t_file_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_first_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_out_kind;
    logic [7:0]  o_out_byte;
    logic [19:0] o_out_offset;
    logic [14:0] o_string_index;
    logic        o_overflow;
    logic        o_last_of_run;

    t_file_byte         pending_bytes[$];
    lprbr_pkg::t_result expected_records[$];
    int         errors = 0;
    int         records_seen = 0;
    bit         quiet = 1'b0;
    int         src_gap = 0;
    int         sink_gap = 0;
    int         hold_left = 0;
    bit         hold_used = 1'b0;

    lprbr_pkg::t_phase pr_phase;
    logic [2:0]  pr_hdr_pos;
    logic [7:0]  pr_count_lo;
    logic [15:0] pr_total;
    logic [14:0] pr_done;
    logic [7:0]  pr_len_lo;
    logic [15:0] pr_left;
    logic [31:0] pr_offset;

    length_prefixed_record_bom_rewriter #(
        .OFFSET_BITS(OFFSET_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_first_byte  (i_first_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_kind    (o_out_kind),
        .o_out_byte    (o_out_byte),
        .o_out_offset  (o_out_offset),
        .o_string_index(o_string_index),
        .o_overflow    (o_overflow),
        .o_last_of_run (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    task automatic clear_parser();
        pr_phase    = lprbr_pkg::PH_HEADER;
        pr_hdr_pos  = 3'd0;
        pr_count_lo = 8'h00;
        pr_total    = 16'd0;
        pr_done     = 15'd0;
        pr_len_lo   = 8'h00;
        pr_left     = 16'd0;
        pr_offset   = 32'd0;
    endtask

    task automatic push_record(input logic kind, input logic [7:0] data,
                               input logic [31:0] off, input logic last);
        lprbr_pkg::t_result r;
        r.kind     = kind;
        r.data     = data;
        r.offset   = off[19:0];
        r.index    = pr_done;
        r.overflow = (off >= OFFSET_TOP);
        r.last     = last;
        expected_records.push_back(r);
    endtask

    task automatic take_store_offset(output logic [31:0] off);
        off = pr_offset;
        if (pr_offset < OFFSET_TOP) begin
            pr_offset = pr_offset + 32'd1;
        end
    endtask

    task automatic rewrite_byte(input logic [7:0] b, input logic first);
        logic [15:0] raw;
        logic [31:0] off;
        if (first) begin
            clear_parser();
        end
        case (pr_phase)
            lprbr_pkg::PH_HEADER: begin
                if (pr_hdr_pos == lprbr_pkg::COUNT_LO_POS) begin
                    pr_count_lo = b;
                end else if (pr_hdr_pos == lprbr_pkg::COUNT_HI_POS) begin
                    raw = {b, pr_count_lo};
                    pr_total = raw[15] ? 16'd0 : raw;
                end
                if (pr_hdr_pos == lprbr_pkg::COUNT_HI_POS) begin
                    pr_hdr_pos = 3'd0;
                    pr_phase = lprbr_pkg::PH_LEN_LO;
                end else begin
                    pr_hdr_pos = pr_hdr_pos + 3'd1;
                end
            end
            lprbr_pkg::PH_LEN_LO: begin
                if ({1'b0, pr_done} < pr_total) begin
                    pr_len_lo = b;
                    pr_phase = lprbr_pkg::PH_LEN_HI;
                end
            end
            lprbr_pkg::PH_LEN_HI: begin
                raw = {b, pr_len_lo};
                push_record(lprbr_pkg::KIND_START, 8'h00, pr_offset, 1'b0);
                take_store_offset(off);
                push_record(lprbr_pkg::KIND_DATA, lprbr_pkg::BOM_FIRST, off, 1'b0);
                take_store_offset(off);
                push_record(lprbr_pkg::KIND_DATA, lprbr_pkg::BOM_SECOND, off, 1'b1);
                if (raw == 16'd0) begin
                    pr_done = pr_done + 15'd1;
                    pr_phase = lprbr_pkg::PH_LEN_LO;
                end else begin
                    pr_left = raw;
                    pr_phase = lprbr_pkg::PH_PAYLOAD;
                end
            end
            default: begin
                take_store_offset(off);
                push_record(lprbr_pkg::KIND_DATA, b, off, 1'b1);
                if (pr_left != 16'd0) begin
                    pr_left = pr_left - 16'd1;
                end
                if (pr_left == 16'd0) begin
                    pr_done = pr_done + 15'd1;
                    pr_phase = lprbr_pkg::PH_LEN_LO;
                end
            end
        endcase
    endtask

    task automatic check_record(input lprbr_pkg::t_result got);
        lprbr_pkg::t_result want;
        records_seen++;
        if (expected_records.size() == 0) begin
            $error("Unexpected output transaction with no record pending.");
            errors++;
        end else begin
            want = expected_records.pop_front();
            if (got.kind !== want.kind) begin
                $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.data !== want.data) begin
                $error("out_byte: expected %0h, got %0h", want.data, got.data);
                errors++;
            end
            if (got.offset !== want.offset) begin
                $error("out_offset: expected %0d, got %0d", want.offset, got.offset);
                errors++;
            end
            if (got.index !== want.index) begin
                $error("string_index: expected %0d, got %0d", want.index, got.index);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_of_run: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_file_byte item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                rewrite_byte(i_data_byte, i_first_byte);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    item = pending_bytes.pop_front();
                    i_in_valid <= 1'b1;
                    i_data_byte <= item.data;
                    i_first_byte <= item.first;
                    if (!quiet && $urandom_range(0, 7) == 0) begin
                        src_gap = $urandom_range(1, 15);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_record({o_out_kind, o_out_byte, o_out_offset, o_string_index,
                              o_overflow, o_last_of_run});
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!hold_used && records_seen >= 40) begin
                hold_used = 1'b1;
                hold_left = 59;
                i_out_stall <= 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 14);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic add_byte(input logic [7:0] data, input logic first);
        t_file_byte item;
        item.data = data;
        item.first = first;
        pending_bytes.push_back(item);
    endtask

    task automatic add_header(input logic [15:0] count);
        for (int i = 0; i < 8; i++) begin
            if (i == 6) begin
                add_byte(count[7:0], 1'b0);
            end else if (i == 7) begin
                add_byte(count[15:8], 1'b0);
            end else begin
                add_byte(8'($urandom_range(0, 255)), i == 0);
            end
        end
    endtask

    task automatic add_string(input logic [15:0] len, input int sent);
        add_byte(len[7:0], 1'b0);
        add_byte(len[15:8], 1'b0);
        for (int i = 0; i < sent; i++) begin
            add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || i_in_valid || expected_records.size() > 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int          pick;
        int          strings;
        int          sent;
        int          items_made;
        logic [15:0] count;
        logic [15:0] len;

        clear_parser();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_header(16'd2);
        add_string(16'd0, 0);
        add_string(16'd2, 0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h5A, 1'b0);
        add_header(16'hFFFF);
        add_byte(8'h00, 1'b0);
        wait_drained();

        items_made = 0;
        while (items_made < 200) begin
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)),
                                                       1'($urandom_range(0, 1)));
            end else begin
                strings = (pick <= 2) ? 0 : $urandom_range(0, 4);
                if (pick == 1) begin
                    count = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
                end else if (pick == 2) begin
                    count = 16'd0;
                end else if (pick == 3) begin
                    count = 16'($urandom_range(strings + 1, 16'h7FFF));
                end else begin
                    count = 16'(strings);
                end
                add_header(count);
                items_made += 8;
                for (int s = 0; s < strings; s++) begin
                    len = 16'($urandom_range(0, 6));
                    sent = (pick == 3 && s == strings - 1) ? $urandom_range(0, len) : len;
                    add_string(len, sent);
                    items_made += 2 + sent;
                end
                repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        wait_drained();

        // The closing files run back to back with no idling on either side.
        quiet = 1'b1;
        add_header(16'd1);
        add_string(16'd3, 3);
        add_byte(8'($urandom_range(0, 255)), 1'b0);
        add_byte(8'($urandom_range(0, 255)), 1'b0);
        add_header(16'd1);
        add_string(16'd1, 1);
        wait_drained();
        repeat (20) @(negedge i_clk);

        if (errors == 0 && expected_records.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

FILE: length_prefixed_record_bom_rewriter.f
sv/lprbr_pkg.sv
sv/length_prefixed_record_bom_rewriter.sv
tb/tb_top.sv
